// ===== rtl/periodic_task_dispatcher_top_defines.svh =====
// Assertion macros for the periodic task dispatcher.
`ifndef PERIODIC_TASK_DISPATCHER_TOP_DEFINES_SVH
`define PERIODIC_TASK_DISPATCHER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PTD_ASSERT(lbl, prop, msg)
`define PTD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/ptd_pkg.sv =====
package ptd_pkg;

  localparam int unsigned TASKS        = 6;
  localparam int unsigned PRIORITY_MAX = 5;

  localparam int unsigned ENTRY_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int unsigned PRIO_W  = (PRIORITY_MAX > 0) ? $clog2(PRIORITY_MAX + 1) : 1;

  localparam logic [31:0] BOOT_DELAY_MS = 32'd2000;

  typedef enum logic {
    OP_POLL  = 1'b0,
    OP_WRITE = 1'b1
  } ptd_op_e;

  typedef enum logic [2:0] {
    FLD_ID    = 3'd0,
    FLD_EN    = 3'd1,
    FLD_START = 3'd2,
    FLD_INTV  = 3'd3,
    FLD_LAST  = 3'd4,
    FLD_STAT  = 3'd5,
    FLD_PRIO  = 3'd6
  } ptd_field_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } ptd_state_e;

  function automatic logic [31:0] default_interval(int unsigned k);
    logic [31:0] v;
    case (k)
      0:       v = 32'd2;
      1:       v = 32'd100;
      2:       v = 32'd1000;
      3:       v = 32'd10;
      4:       v = 32'd1;
      5:       v = 32'd500;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] reset_word(ptd_field_e f, int unsigned k);
    logic [31:0] v;
    case (f)
      FLD_ID:    v = 32'(k);
      FLD_EN:    v = (k < 6) ? 32'd1 : 32'd0;
      FLD_START: v = (k < 6 && k != 3) ? BOOT_DELAY_MS : 32'd0;
      FLD_INTV:  v = default_interval(k);
      FLD_PRIO:  v = 32'd1;
      default:   v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/periodic_task_dispatcher_top.sv =====
// Channel  | Direction | tdata (low bit up)                          | tuser
// s_axis   | in        | now_ms 32, task_index 4, field_select 3,    | op
//          |           | field_value 32, one zero pad bit            |
// m_axis   | out       | task_id 32                                  | found
//
// A write is applied in the cycle of its transfer.
// A poll is accepted, then steps through the table entries in order through
// the shared eligibility compare, then commits.
// The result sits in an output register; a poll waits in its commit step
// while an earlier result has not been taken.
// The task table loads its default contents at reset, no clearing pass.
`include "periodic_task_dispatcher_top_defines.svh"

module periodic_task_dispatcher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // now_ms, task_index, field_select, field_value
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // task_id
  output logic        m_axis_tuser    // found
);

  localparam int unsigned EW = ptd_pkg::ENTRY_W;
  localparam int unsigned PW = ptd_pkg::PRIO_W;

  logic [31:0] id_q    [ptd_pkg::TASKS];
  logic [31:0] en_q    [ptd_pkg::TASKS];
  logic [31:0] start_q [ptd_pkg::TASKS];
  logic [31:0] intv_q  [ptd_pkg::TASKS];
  logic [31:0] last_q  [ptd_pkg::TASKS];
  logic [31:0] stat_q  [ptd_pkg::TASKS];
  logic [31:0] prio_q  [ptd_pkg::TASKS];

  ptd_pkg::ptd_state_e state_q, state_d;
  logic [EW-1:0] k_q, k_d;
  logic [EW-1:0] best_q, best_d;
  logic [PW-1:0] best_prio_q, best_prio_d;
  logic [31:0]   best_id_q, best_id_d;
  logic          have_q, have_d;
  logic [31:0]   now_q, now_d;
  logic          m_valid_q, m_valid_d;
  logic          m_found_q, m_found_d;
  logic [31:0]   m_id_q, m_id_d;

  logic          s_xfer;
  logic          wr_en;
  logic          commit;
  logic          elig;
  logic          better;
  logic [31:0]   age;
  logic [EW-1:0] wr_idx;
  ptd_pkg::ptd_field_e wr_fld;
  logic [31:0]   wr_val;

  assign s_axis_tready = (state_q == ptd_pkg::S_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign wr_idx        = s_axis_tdata[32 +: EW];
  assign wr_fld        = ptd_pkg::ptd_field_e'(s_axis_tdata[38:36]);
  assign wr_val        = s_axis_tdata[70:39];
  assign wr_en         = s_xfer && (ptd_pkg::ptd_op_e'(s_axis_tuser) == ptd_pkg::OP_WRITE)
                         && ({1'b0, s_axis_tdata[35:32]} < 5'(ptd_pkg::TASKS));

  assign age    = now_q - last_q[k_q];
  assign elig   = (en_q[k_q] == 32'd1) && (start_q[k_q] < now_q) && (age > intv_q[k_q])
                  && !stat_q[k_q][31] && (prio_q[k_q] <= 32'(ptd_pkg::PRIORITY_MAX));
  assign better = elig && (!have_q || (prio_q[k_q][PW-1:0] < best_prio_q));
  assign commit = (state_q == ptd_pkg::S_DONE) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    best_d      = best_q;
    best_prio_d = best_prio_q;
    best_id_d   = best_id_q;
    have_d      = have_q;
    now_d       = now_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_found_d   = m_found_q;
    m_id_d      = m_id_q;
    case (state_q)
      ptd_pkg::S_IDLE: begin
        if (s_xfer && (ptd_pkg::ptd_op_e'(s_axis_tuser) == ptd_pkg::OP_POLL)) begin
          now_d   = s_axis_tdata[31:0];
          k_d     = '0;
          have_d  = 1'b0;
          state_d = ptd_pkg::S_SCAN;
        end
      end
      ptd_pkg::S_SCAN: begin
        if (better) begin
          have_d      = 1'b1;
          best_d      = k_q;
          best_prio_d = prio_q[k_q][PW-1:0];
          best_id_d   = id_q[k_q];
        end
        if (k_q == EW'(ptd_pkg::TASKS - 1)) begin
          state_d = ptd_pkg::S_DONE;
        end else begin
          k_d = k_q + EW'(1);
        end
      end
      ptd_pkg::S_DONE: begin
        if (commit) begin
          m_valid_d = 1'b1;
          m_found_d = have_q;
          m_id_d    = have_q ? best_id_q : 32'd0;
          state_d   = ptd_pkg::S_IDLE;
        end
      end
      default: state_d = ptd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ptd_pkg::S_IDLE;
      m_valid_q <= 1'b0;
      have_q    <= 1'b0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      have_q    <= have_d;
      k_q       <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q      <= best_d;
    best_prio_q <= best_prio_d;
    best_id_q   <= best_id_d;
    now_q       <= now_d;
    m_found_q   <= m_found_d;
    m_id_q      <= m_id_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < ptd_pkg::TASKS; k++) begin
        id_q[k]    <= ptd_pkg::reset_word(ptd_pkg::FLD_ID, k);
        en_q[k]    <= ptd_pkg::reset_word(ptd_pkg::FLD_EN, k);
        start_q[k] <= ptd_pkg::reset_word(ptd_pkg::FLD_START, k);
        intv_q[k]  <= ptd_pkg::reset_word(ptd_pkg::FLD_INTV, k);
        last_q[k]  <= ptd_pkg::reset_word(ptd_pkg::FLD_LAST, k);
        stat_q[k]  <= ptd_pkg::reset_word(ptd_pkg::FLD_STAT, k);
        prio_q[k]  <= ptd_pkg::reset_word(ptd_pkg::FLD_PRIO, k);
      end
    end else if (wr_en) begin
      case (wr_fld)
        ptd_pkg::FLD_ID:    id_q[wr_idx]    <= wr_val;
        ptd_pkg::FLD_EN:    en_q[wr_idx]    <= wr_val;
        ptd_pkg::FLD_START: start_q[wr_idx] <= wr_val;
        ptd_pkg::FLD_INTV:  intv_q[wr_idx]  <= wr_val;
        ptd_pkg::FLD_LAST:  last_q[wr_idx]  <= wr_val;
        ptd_pkg::FLD_STAT:  stat_q[wr_idx]  <= wr_val;
        ptd_pkg::FLD_PRIO:  prio_q[wr_idx]  <= wr_val;
        default: ;
      endcase
    end else if (commit && have_q) begin
      last_q[best_q] <= now_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = m_id_q;

  `PTD_ASSERT(a_none_is_zero, (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 32'd0), "empty result carries a nonzero id")
  `PTD_ASSERT(a_poll_scans, (s_xfer && !s_axis_tuser) |=> (state_q == ptd_pkg::S_SCAN && k_q == '0), "poll did not start a scan")
  `PTD_ASSERT(a_scan_range, (state_q == ptd_pkg::S_SCAN) |-> (k_q <= EW'(ptd_pkg::TASKS - 1)), "scan index beyond table")
  `PTD_ASSERT_ALWAYS(a_commit_stamps, (rst_ni && $past(rst_ni) && $past(commit) && $past(have_q)) |-> (last_q[$past(best_q)] == $past(now_q)), "chosen entry did not record its run time")

endmodule
